// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/core/kudat_pkg.sv =====
// ---------------------------------------------------------------------------
// kudat_pkg
// Phase codes and time limits of the up/down alarm timer.
// ---------------------------------------------------------------------------
package kudat_pkg;

	typedef enum logic [2:0] {
		PH_CD_START = 3'd0,
		PH_CD_ENTRY = 3'd1,
		PH_CD_RUN   = 3'd2,
		PH_CD_END   = 3'd3,
		PH_CU_START = 3'd4,
		PH_CU_ENTRY = 3'd5,
		PH_CU_RUN   = 3'd6,
		PH_CU_END   = 3'd7
	} phase_t;

	localparam logic [5:0] SEC_MAX = 6'd59;
	localparam logic [3:0] MIN_MAX = 4'd9;

endpackage

// ===== rtl/core/kudat_if.sv =====
// ---------------------------------------------------------------------------
// kudat_in_if / kudat_out_if
// Valid/ready channels for timer events and for timer status words.
// ---------------------------------------------------------------------------
interface kudat_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [3:0] key;

	modport source (output valid, output mode, output key, input ready);
	modport sink   (input valid, input mode, input key, output ready);
endinterface

interface kudat_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] phase;
	logic [3:0] shown_minutes;
	logic [5:0] shown_seconds;
	logic       alarm_on;

	modport source (output valid, output phase, output shown_minutes,
		output shown_seconds, output alarm_on, input ready);
	modport sink   (input valid, input phase, input shown_minutes,
		input shown_seconds, input alarm_on, output ready);
endinterface

// ===== rtl/core/keypad_up_down_alarm_timer_unit.sv =====
// ---------------------------------------------------------------------------
// keypad_up_down_alarm_timer_unit
// Eight-phase minutes/seconds timer driven by key and one-second tick words.
// ---------------------------------------------------------------------------
// Every event word (a decoded key or a one-second tick) produces exactly one
// status word: phase, shown minutes and seconds, and the alarm flag. One word
// is taken per cycle while the output is not stalled; an event is held first
// in the input register and its status word then in the result register,
// which presents it, with the whole state update done in one pass between them. A
// stalled output backs up into the input register before ready drops.
module keypad_up_down_alarm_timer_unit (
	input  logic        clk,
	input  logic        arst_n,
	kudat_in_if.sink    in,
	kudat_out_if.source out
);
	import kudat_pkg::*;

	localparam logic [3:0] KEY_0 = 4'd0;
	localparam logic [3:0] KEY_9 = 4'd9;
	localparam logic [3:0] KEY_A = 4'd10;
	localparam logic [3:0] KEY_B = 4'd11;
	localparam logic [3:0] KEY_C = 4'd12;
	localparam logic [3:0] KEY_D = 4'd13;
	localparam logic [3:0] TENS_MAX = 4'd5;
	localparam logic [5:0] RADIX = 6'd10;

	typedef struct packed {
		phase_t     phase;
		logic [3:0] tgt_min;
		logic [5:0] tgt_sec;
		logic [3:0] ela_min;
		logic [5:0] ela_sec;
		logic [1:0] digits;
		logic       count_up;
	} timer_state_t;

	timer_state_t state_q, nxt;

	logic       valid_s1;
	logic       mode_s1;
	logic [3:0] key_s1;

	logic       out_valid_q;
	phase_t     phase_s2;
	logic [3:0] minutes_s2;
	logic [5:0] seconds_s2;
	logic       alarm_s2;

	logic       advance;
	logic       in_start, in_entry;
	logic [5:0] sec_shifted;
	logic       show_elapsed;

	assign advance  = !out_valid_q || out.ready;
	assign in.ready = !valid_s1 || advance;

	assign in_start = (state_q.phase == PH_CD_START) || (state_q.phase == PH_CU_START);
	assign in_entry = (state_q.phase == PH_CD_ENTRY) || (state_q.phase == PH_CU_ENTRY);
	assign sec_shifted = 6'(state_q.tgt_sec * RADIX + {2'b00, key_s1});

	always_comb begin
		nxt = state_q;
		if (mode_s1) begin
			if (state_q.phase == PH_CD_RUN) begin
				if (state_q.tgt_sec == '0) begin
					if (state_q.tgt_min == '0) begin
						nxt.phase = PH_CD_END;
					end else begin
						nxt.tgt_min = state_q.tgt_min - 4'd1;
						nxt.tgt_sec = SEC_MAX;
					end
				end else begin
					nxt.tgt_sec = state_q.tgt_sec - 6'd1;
				end
			end else if (state_q.phase == PH_CU_RUN) begin
				if (state_q.ela_sec == state_q.tgt_sec && state_q.ela_min == state_q.tgt_min) begin
					nxt.phase = PH_CU_END;
				end else if (state_q.ela_sec >= SEC_MAX) begin
					nxt.ela_sec = '0;
					nxt.ela_min = state_q.ela_min + 4'd1;
				end else begin
					nxt.ela_sec = state_q.ela_sec + 6'd1;
				end
			end
		end else begin
			unique case (key_s1) inside
				[KEY_0:KEY_9]: begin
					if (in_entry) begin
						case (state_q.digits)
							2'd0: begin
								nxt.tgt_min = key_s1;
								nxt.digits  = 2'd1;
							end
							2'd1: begin
								// tens of seconds: refuse 6 and above
								if (key_s1 <= TENS_MAX) begin
									nxt.tgt_sec = sec_shifted;
									nxt.digits  = 2'd2;
								end
							end
							2'd2: begin
								nxt.tgt_sec = sec_shifted;
								nxt.digits  = 2'd3;
							end
							default: ;
						endcase
					end
				end
				KEY_A: begin
					if (in_entry) nxt.phase = phase_t'(state_q.phase + 3'd1);
				end
				KEY_B: begin
					nxt.phase   = state_q.count_up ? PH_CU_START : PH_CD_START;
					nxt.tgt_min = '0;
					nxt.tgt_sec = '0;
					nxt.ela_min = '0;
					nxt.ela_sec = '0;
					nxt.digits  = '0;
				end
				KEY_C: begin
					if (in_start) begin
						nxt.count_up = !state_q.count_up;
						nxt.phase    = state_q.count_up ? PH_CD_START : PH_CU_START;
						nxt.tgt_min  = '0;
						nxt.tgt_sec  = '0;
						nxt.ela_min  = '0;
						nxt.ela_sec  = '0;
						nxt.digits   = '0;
					end
				end
				KEY_D: begin
					if (in_start) nxt.phase = phase_t'(state_q.phase + 3'd1);
				end
				default: ;
			endcase
		end
	end

	assign show_elapsed = (nxt.phase == PH_CU_RUN) || (nxt.phase == PH_CU_END);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= '{phase: PH_CD_START, default: '0};
		end else begin
			if (in.valid && in.ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
				if (valid_s1) state_q <= nxt;
			end
		end
	end

	// payload registers: no reset
	always_ff @(posedge clk) begin
		if (in.valid && in.ready) begin
			mode_s1 <= in.mode;
			key_s1  <= in.key;
		end
		if (advance && valid_s1) begin
			phase_s2   <= nxt.phase;
			minutes_s2 <= show_elapsed ? nxt.ela_min : nxt.tgt_min;
			seconds_s2 <= show_elapsed ? nxt.ela_sec : nxt.tgt_sec;
			alarm_s2   <= (nxt.phase == PH_CD_END) || (nxt.phase == PH_CU_END);
		end
	end

	assign out.valid         = out_valid_q;
	assign out.phase         = phase_s2;
	assign out.shown_minutes = minutes_s2;
	assign out.shown_seconds = seconds_s2;
	assign out.alarm_on      = alarm_s2;

endmodule

// ===== rtl/core/kudat_checker.sv =====
// ---------------------------------------------------------------------------
// kudat_checker
// Port-level checks on the timer, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module kudat_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] out_phase,
	input logic [3:0] out_minutes,
	input logic [5:0] out_seconds,
	input logic       out_alarm
);
	import kudat_pkg::*;

	logic unused_in_valid;
	assign unused_in_valid = in_valid;

	// input stalls only behind a stalled output word
	`ASSERT_IMPLY(a_ready_low_only_on_stall, clk, arst_n, !in_ready, out_valid && !out_ready)

	// hold a stalled status word
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(out_phase) && $stable(out_minutes) && $stable(out_seconds)
		&& $stable(out_alarm))

	// alarm follows the end phases
	`ASSERT_IMPLY(a_alarm_phase, clk, arst_n, out_valid,
		out_alarm == ((out_phase == PH_CD_END) || (out_phase == PH_CU_END)))

	// shown time never leaves 9:59
	`ASSERT_IMPLY(a_time_range, clk, arst_n, out_valid,
		(out_seconds <= SEC_MAX) && (out_minutes <= MIN_MAX))

endmodule

bind keypad_up_down_alarm_timer_unit kudat_checker u_kudat_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in.valid),
	.in_ready    (in.ready),
	.out_valid   (out.valid),
	.out_ready   (out.ready),
	.out_phase   (out.phase),
	.out_minutes (out.shown_minutes),
	.out_seconds (out.shown_seconds),
	.out_alarm   (out.alarm_on)
);
